// ----- rtl/core/rrsp_pkg.sv -----
// Shared types and constants for the round-robin stripe placement block.
// No dependencies; every other file of the block refers to it by scoped names.
package rrsp_pkg;

   localparam int MAX_SERVERS_DEF = 64;
   localparam int QUEUE_DEPTH     = 4;
   localparam int ID_W            = 32;
   localparam int ENTRY_W         = 6;
   localparam int CNT7_W          = 7;
   localparam int SLOT_W          = 6;
   localparam int STATUS_W        = 2;
   localparam int NEED_W          = 14;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd2;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_PLACE = 1'b1;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_PLACE,
      KIND_BAD
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [ENTRY_W-1:0]  entry_index;
      logic                entry_online;
      logic [ID_W-1:0]     entry_id;
      logic [CNT7_W-1:0]   stripes;
      logic [CNT7_W-1:0]   mirrors;
   } item_type;

   typedef struct packed {
      logic            start;
      logic [ID_W-1:0] dividend;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [ID_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- rtl/core/rrsp_if.sv -----
// Channel interfaces: request, response and control register write.
// Depends on rrsp_pkg for field widths.
interface rrsp_req_if;
   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic [rrsp_pkg::ENTRY_W-1:0]   entry_index;
   logic                           entry_online;
   logic [rrsp_pkg::ID_W-1:0]      entry_id;
   logic [rrsp_pkg::CNT7_W-1:0]    stripes_wanted;
   logic [rrsp_pkg::CNT7_W-1:0]    mirrors_wanted;
   modport source (output valid, req_type, entry_index, entry_online, entry_id,
                   stripes_wanted, mirrors_wanted, input ready);
   modport sink (input valid, req_type, entry_index, entry_online, entry_id,
                 stripes_wanted, mirrors_wanted, output ready);
endinterface

interface rrsp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [rrsp_pkg::ID_W-1:0]      server_id;
   logic [rrsp_pkg::SLOT_W-1:0]    slot;
   logic [rrsp_pkg::CNT7_W-1:0]    stripes_granted;
   logic [rrsp_pkg::STATUS_W-1:0]  status;
   logic                           last;
   modport source (output valid, server_id, slot, stripes_granted, status, last,
                   input ready);
   modport sink (input valid, server_id, slot, stripes_granted, status, last,
                 output ready);
endinterface

interface rrsp_csr_if;
   logic                           valid;
   logic                           ready;
   logic [rrsp_pkg::CNT7_W-1:0]    data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ----- rtl/core/rrsp_front.sv -----
// Front end: decode incoming words into load, place or bad-request items.
// Depends on rrsp_pkg and rrsp_req_if.
module rrsp_front (
   rrsp_req_if.sink            req,
   input  logic                push_ready,
   output logic                push_valid,
   output rrsp_pkg::item_type  push_item
);

   // classify: a place with a zero count is rejected up front
   always_comb begin
      push_item.entry_index  = req.entry_index;
      push_item.entry_online = req.entry_online;
      push_item.entry_id     = req.entry_id;
      push_item.stripes      = req.stripes_wanted;
      push_item.mirrors      = req.mirrors_wanted;
      if (req.req_type == rrsp_pkg::REQ_LOAD) begin
         push_item.kind = rrsp_pkg::KIND_LOAD;
      end else if (req.stripes_wanted == '0 || req.mirrors_wanted == '0) begin
         push_item.kind = rrsp_pkg::KIND_BAD;
      end else begin
         push_item.kind = rrsp_pkg::KIND_PLACE;
      end
   end

   assign push_valid = req.valid;
   assign req.ready  = push_ready;

endmodule

// ----- rtl/core/rrsp_queue.sv -----
// Short item queue between the front end and the placement engine.
// Depends on rrsp_pkg for the item type and depth.
module rrsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  rrsp_pkg::item_type  push_item,
   output logic                pop_valid,
   input  logic                pop,
   output rrsp_pkg::item_type  pop_item
);

   localparam int PTR_W = $clog2(rrsp_pkg::QUEUE_DEPTH);

   rrsp_pkg::item_type  mem_ff [rrsp_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]      fill_ff, fill_in;
   logic                do_push, do_pop;

   assign push_ready = (fill_ff != (PTR_W+1)'(rrsp_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // store payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/core/rrsp_divider.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rrsp_pkg for the request and result types.
module rrsp_divider #(
   parameter int DIV_W = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rrsp_pkg::div_req_type div_req,
   input  logic [DIV_W-1:0]      divisor,
   output rrsp_pkg::div_rsp_type div_rsp,
   output logic [DIV_W-1:0]      remainder
);

   localparam int STEP_W = $clog2(rrsp_pkg::ID_W + 1);

   logic [rrsp_pkg::ID_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0]          rem_ff, rem_in;
   logic [DIV_W-1:0]          dsr_ff, dsr_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [DIV_W:0]            shifted;

   assign shifted = {rem_ff, quo_ff[rrsp_pkg::ID_W-1]};

   // shift one dividend bit in, subtract when it fits
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = DIV_W'(shifted - {1'b0, dsr_ff});
            quo_in = {quo_ff[rrsp_pkg::ID_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_W-1:0];
            quo_in = {quo_ff[rrsp_pkg::ID_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(rrsp_pkg::ID_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
   assign remainder        = rem_ff;

endmodule

// ----- rtl/core/rrsp_engine.sv -----
// Back end: server table, online scan, degrade, rotation and result output.
// Depends on rrsp_pkg, rrsp_rsp_if, rrsp_csr_if and rrsp_divider.
module rrsp_engine #(
   parameter int MAX_SERVERS = rrsp_pkg::MAX_SERVERS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop,
   input  rrsp_pkg::item_type  pop_item,
   rrsp_csr_if.sink            csr,
   rrsp_rsp_if.source          rsp
);

   localparam int IDX_W  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CNT_W  = $clog2(MAX_SERVERS + 1);
   localparam int LOAD_W = (IDX_W > rrsp_pkg::ENTRY_W) ? IDX_W + 1 : rrsp_pkg::ENTRY_W + 1;
   localparam int ID_W   = rrsp_pkg::ID_W;
   localparam int NW     = rrsp_pkg::NEED_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_CHECK, ST_DEGRADE, ST_START_MOD, ST_MOD_WAIT,
      ST_RD_LIST, ST_RD_ID, ST_EMIT, ST_ERROR
   } state_type;

   state_type                   state_ff;
   logic [rrsp_pkg::CNT7_W-1:0] server_count_ff;
   logic [MAX_SERVERS-1:0]      online_ff;
   logic [ID_W-1:0]             ids_mem [MAX_SERVERS];
   logic [IDX_W-1:0]            list_mem [MAX_SERVERS];
   logic [IDX_W-1:0]            list_q_ff;
   logic [ID_W-1:0]             id_q_ff;
   logic [CNT_W-1:0]            scan_ff;
   logic [CNT_W-1:0]            oc_ff;
   logic [rrsp_pkg::CNT7_W-1:0] stripes_ff;
   logic [rrsp_pkg::CNT7_W-1:0] mirrors_ff;
   logic [NW-1:0]               need_ff;
   logic [NW-1:0]               k_ff;
   logic [IDX_W-1:0]            pos_ff;
   logic [ID_W-1:0]             v_ff;
   logic [ID_W-1:0]             counter_ff;
   logic [rrsp_pkg::STATUS_W-1:0] err_ff;

   logic                        rsp_valid_ff;
   logic [ID_W-1:0]             rsp_id_ff;
   logic [rrsp_pkg::SLOT_W-1:0] rsp_slot_ff;
   logic [rrsp_pkg::CNT7_W-1:0] rsp_granted_ff;
   logic [rrsp_pkg::STATUS_W-1:0] rsp_status_ff;
   logic                        rsp_last_ff;

   logic [CNT_W-1:0]            count_sat;
   logic [NW-1:0]               product;
   logic [LOAD_W-1:0]           load_ext;
   logic                        load_hit;
   logic                        out_free;
   logic                        emit_now;
   logic                        is_last;
   logic [IDX_W-1:0]            pos_next;
   rrsp_pkg::div_req_type       div_req;
   rrsp_pkg::div_rsp_type       div_rsp;
   logic [CNT_W-1:0]            div_divisor;
   logic [CNT_W-1:0]            div_rem;

   rrsp_divider #(.DIV_W(CNT_W)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .div_req   (div_req),
      .divisor   (div_divisor),
      .div_rsp   (div_rsp),
      .remainder (div_rem)
   );

   // saturate table size, decode load address
   assign count_sat = (32'(server_count_ff) > MAX_SERVERS) ? CNT_W'(MAX_SERVERS)
                                                           : CNT_W'(server_count_ff);
   assign product   = NW'(stripes_ff) * NW'(mirrors_ff);
   assign load_ext  = LOAD_W'(pop_item.entry_index);
   assign load_hit  = (32'(load_ext) < MAX_SERVERS);
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign emit_now  = out_free && (state_ff == ST_EMIT || state_ff == ST_ERROR);
   assign is_last   = (k_ff + 1'b1 == need_ff);
   assign pos_next  = (v_ff == '1) ? '0 :
                      (CNT_W'(pos_ff) + 1'b1 == oc_ff) ? '0 : pos_ff + 1'b1;
   assign pop       = (state_ff == ST_IDLE) && pop_valid;
   assign csr.ready = 1'b1;

   // kick the divider: degrade quotient or rotation start position
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = ID_W'(oc_ff);
      div_divisor      = CNT_W'(mirrors_ff);
      if (state_ff == ST_CHECK) begin
         div_req.start = !(NW'(oc_ff) < NW'(mirrors_ff)) && (NW'(oc_ff) < product);
      end else if (state_ff == ST_START_MOD) begin
         div_req.start    = 1'b1;
         div_req.dividend = counter_ff;
         div_divisor      = oc_ff;
      end
   end

   // sequence one queued item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         server_count_ff <= '0;
         online_ff       <= '0;
         counter_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr.valid) begin
            server_count_ff <= csr.data;
         end
         // drop the output word once taken, unless a new one replaces it
         if (rsp_valid_ff && rsp.ready && !emit_now) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (pop_valid) begin
                  unique case (pop_item.kind)
                     rrsp_pkg::KIND_LOAD: begin
                        if (load_hit) begin
                           online_ff[load_ext[IDX_W-1:0]] <= pop_item.entry_online;
                        end
                     end
                     rrsp_pkg::KIND_BAD: begin
                        err_ff   <= rrsp_pkg::STATUS_INVALID;
                        state_ff <= ST_ERROR;
                     end
                     default: begin
                        stripes_ff <= pop_item.stripes;
                        mirrors_ff <= pop_item.mirrors;
                        scan_ff    <= '0;
                        oc_ff      <= '0;
                        state_ff   <= ST_SCAN;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (scan_ff < count_sat) begin
                  if (online_ff[scan_ff[IDX_W-1:0]]) begin
                     oc_ff <= oc_ff + 1'b1;
                  end
                  scan_ff <= scan_ff + 1'b1;
               end else begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (NW'(oc_ff) < NW'(mirrors_ff)) begin
                  err_ff   <= rrsp_pkg::STATUS_NOSPACE;
                  state_ff <= ST_ERROR;
               end else if (NW'(oc_ff) < product) begin
                  state_ff <= ST_DEGRADE;
               end else begin
                  state_ff <= ST_START_MOD;
               end
            end
            ST_DEGRADE: begin
               if (div_rsp.done) begin
                  stripes_ff <= (div_rsp.quotient == '0) ? rrsp_pkg::CNT7_W'(1)
                                : div_rsp.quotient[rrsp_pkg::CNT7_W-1:0];
                  state_ff   <= ST_START_MOD;
               end
            end
            ST_START_MOD: begin
               need_ff  <= product;
               state_ff <= ST_MOD_WAIT;
            end
            ST_MOD_WAIT: begin
               if (div_rsp.done) begin
                  pos_ff   <= div_rem[IDX_W-1:0];
                  v_ff     <= counter_ff;
                  k_ff     <= '0;
                  state_ff <= ST_RD_LIST;
               end
            end
            ST_RD_LIST: begin
               state_ff <= ST_RD_ID;
            end
            ST_RD_ID: begin
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_id_ff      <= id_q_ff;
                  rsp_slot_ff    <= k_ff[rrsp_pkg::SLOT_W-1:0];
                  rsp_granted_ff <= stripes_ff;
                  rsp_status_ff  <= rrsp_pkg::STATUS_OK;
                  rsp_last_ff    <= is_last;
                  k_ff           <= k_ff + 1'b1;
                  v_ff           <= v_ff + 1'b1;
                  pos_ff         <= pos_next;
                  if (is_last) begin
                     counter_ff <= counter_ff + ID_W'(need_ff);
                     state_ff   <= ST_IDLE;
                  end else begin
                     state_ff <= ST_RD_LIST;
                  end
               end
            end
            ST_ERROR: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_id_ff      <= '0;
                  rsp_slot_ff    <= '0;
                  rsp_granted_ff <= '0;
                  rsp_status_ff  <= err_ff;
                  rsp_last_ff    <= 1'b1;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // server id table: write on load, registered read
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && pop_valid && pop_item.kind == rrsp_pkg::KIND_LOAD
          && load_hit) begin
         ids_mem[load_ext[IDX_W-1:0]] <= pop_item.entry_id;
      end
      id_q_ff <= ids_mem[list_q_ff];
   end

   // online list: append during scan, registered read
   always_ff @(posedge clock) begin
      if (state_ff == ST_SCAN && scan_ff < count_sat && online_ff[scan_ff[IDX_W-1:0]]) begin
         list_mem[oc_ff[IDX_W-1:0]] <= scan_ff[IDX_W-1:0];
      end
      list_q_ff <= list_mem[pos_ff];
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.server_id       = rsp_id_ff;
   assign rsp.slot            = rsp_slot_ff;
   assign rsp.stripes_granted = rsp_granted_ff;
   assign rsp.status          = rsp_status_ff;
   assign rsp.last            = rsp_last_ff;

endmodule

// ----- rtl/core/round_robin_stripe_placement.sv -----
// Round-robin stripe placement. A load is taken in the engine's idle state; a
// place request scans the table up to the server count, divides once when the
// stripe count degrades, divides for the rotation start position, then emits
// each slot after two chained table reads (online list, then server id). A
// zero-count request is rejected without a scan, one with too few online servers after it. One request at a time.
// Synchronous active-high reset clears the online flags, rotation counter,
// server count, queue and output register; the server id table is not cleared.
module round_robin_stripe_placement #(
   parameter int MAX_SERVERS = rrsp_pkg::MAX_SERVERS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   rrsp_req_if.sink    req,
   rrsp_rsp_if.source  rsp,
   rrsp_csr_if.sink    csr
);

   logic                push_valid, push_ready;
   logic                pop_valid, pop;
   rrsp_pkg::item_type  push_item, pop_item;

   rrsp_front u_front (
      .req        (req),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   rrsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item)
   );

   rrsp_engine #(.MAX_SERVERS(MAX_SERVERS)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_item  (pop_item),
      .csr       (csr),
      .rsp       (rsp)
   );

endmodule
